### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sgird_pkg.sv
// ----------------------------------------------------------------------------
// sgird_pkg
// Types and constants for the SGI RLE scanline decoder.
// ----------------------------------------------------------------------------
package sgird_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 7;
    localparam int WIDTH_W     = 16;
    localparam int COL_W       = WIDTH_W + 1;
    localparam int KIND_BIT    = 7;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd1;

    typedef enum logic [1:0] {
        MODE_CTRL    = 2'd0,
        MODE_REPEAT  = 2'd1,
        MODE_LITERAL = 2'd2,
        MODE_STOPPED = 2'd3
    } mode_t;

    typedef struct packed {
        logic               run_valid;
        logic [BYTE_W-1:0]  pixel_value;
        logic [WIDTH_W-1:0] start_column;
        logic [COUNT_W-1:0] run_length;
        logic               line_done;
        logic               line_error;
    } result_t;

endpackage

### hdl/sgird_byte_if.sv
// ----------------------------------------------------------------------------
// sgird_byte_if
// Compressed byte channel: valid/ready with one scanline byte per transfer.
// ----------------------------------------------------------------------------
interface sgird_byte_if;

    logic                           valid;
    logic                           ready;
    logic [sgird_pkg::BYTE_W-1:0]   data_byte;
    logic                           line_end;

    modport source (output valid, output data_byte, output line_end, input ready);
    modport sink   (input valid, input data_byte, input line_end, output ready);

endinterface

### hdl/sgird_run_if.sv
// ----------------------------------------------------------------------------
// sgird_run_if
// Decoded run channel: valid/ready with one run or line status per transfer.
// ----------------------------------------------------------------------------
interface sgird_run_if;

    logic                           valid;
    logic                           ready;
    logic                           run_valid;
    logic [sgird_pkg::BYTE_W-1:0]   pixel_value;
    logic [sgird_pkg::WIDTH_W-1:0]  start_column;
    logic [sgird_pkg::COUNT_W-1:0]  run_length;
    logic                           line_done;
    logic                           line_error;

    modport source (
        output valid, output run_valid, output pixel_value, output start_column,
        output run_length, output line_done, output line_error, input ready
    );
    modport sink (
        input valid, input run_valid, input pixel_value, input start_column,
        input run_length, input line_done, input line_error, output ready
    );

endinterface

### hdl/sgi_rle_scanline_decoder_core.sv
// ----------------------------------------------------------------------------
// sgi_rle_scanline_decoder_core
// SGI 8-bit RLE scanline decoder: bytes in, pixel runs and line status out.
// ----------------------------------------------------------------------------
// A transferred byte is registered in the input register, decoded, and then
// registered in the result register. Throughput: one byte per cycle while the
// run channel does not stall; the input register drains into the result register
// whenever it is empty or being taken, and always when its byte has no result.
// Reset: async active-low; clears line state, line_width returns to 1.
module sgi_rle_scanline_decoder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [sgird_pkg::WIDTH_W-1:0]   cfg_wr_data,
    sgird_byte_if.sink                      byte_in,
    sgird_run_if.source                     run_out
);

    logic [sgird_pkg::WIDTH_W-1:0]  line_width_reg;

    logic                           in_valid_reg;
    logic [sgird_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                           in_last_reg;

    logic                           out_valid_reg;
    sgird_pkg::result_t             out_reg;

    sgird_pkg::result_t             dec_result;
    logic                           dec_has_result;
    logic                           out_free;
    logic                           dec_step;

    assign out_free = !out_valid_reg || run_out.ready;
    assign dec_step = in_valid_reg && (!dec_has_result || out_free);
    assign byte_in.ready = !in_valid_reg || dec_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= sgird_pkg::WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            line_width_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.data_byte;
            in_last_reg <= byte_in.line_end;
        end
    end

    sgird_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (dec_step),
        .data_byte  (in_byte_reg),
        .line_end   (in_last_reg),
        .line_width (line_width_reg),
        .result     (dec_result),
        .has_result (dec_has_result)
    );

    // Result register; hold while the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= dec_step && dec_has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && dec_step && dec_has_result)
        begin
            out_reg <= dec_result;
        end
    end

    assign run_out.valid        = out_valid_reg;
    assign run_out.run_valid    = out_reg.run_valid;
    assign run_out.pixel_value  = out_reg.pixel_value;
    assign run_out.start_column = out_reg.start_column;
    assign run_out.run_length   = out_reg.run_length;
    assign run_out.line_done    = out_reg.line_done;
    assign run_out.line_error   = out_reg.line_error;

endmodule

### hdl/sgird_decode.sv
// ----------------------------------------------------------------------------
// sgird_decode
// Per-line decode state and the single-step packet decode for one byte.
// ----------------------------------------------------------------------------
module sgird_decode (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [sgird_pkg::BYTE_W-1:0]    data_byte,
    input  logic                            line_end,
    input  logic [sgird_pkg::WIDTH_W-1:0]   line_width,
    output sgird_pkg::result_t              result,
    output logic                            has_result
);

    sgird_pkg::mode_t                   mode_reg;
    sgird_pkg::mode_t                   mode_next;
    logic [sgird_pkg::COUNT_W-1:0]      count_reg;
    logic [sgird_pkg::COUNT_W-1:0]      count_next;
    logic [sgird_pkg::COL_W-1:0]        column_reg;
    logic [sgird_pkg::COL_W-1:0]        column_next;
    logic                               error_reg;
    logic                               error_next;

    logic                               place;
    logic [sgird_pkg::COUNT_W-1:0]      place_len;
    logic [sgird_pkg::COL_W:0]          run_end;
    logic                               fits;
    logic                               run;
    logic                               line_bad;

    // Next mode and packet count
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        case (mode_reg)
            sgird_pkg::MODE_CTRL:
            begin
                if (data_byte == '0)
                begin
                    mode_next = sgird_pkg::MODE_STOPPED;
                end
                else
                begin
                    count_next = data_byte[sgird_pkg::COUNT_W-1:0];
                    if (!data_byte[sgird_pkg::KIND_BIT])
                    begin
                        mode_next = sgird_pkg::MODE_REPEAT;
                    end
                    else if (data_byte[sgird_pkg::COUNT_W-1:0] != '0)
                    begin
                        mode_next = sgird_pkg::MODE_LITERAL;
                    end
                    else
                    begin
                        mode_next = sgird_pkg::MODE_CTRL;
                    end
                end
            end
            sgird_pkg::MODE_REPEAT:
            begin
                count_next = '0;
                mode_next  = sgird_pkg::MODE_CTRL;
            end
            sgird_pkg::MODE_LITERAL:
            begin
                count_next = count_reg - sgird_pkg::COUNT_W'(1);
                if (count_reg == sgird_pkg::COUNT_W'(1))
                begin
                    mode_next = sgird_pkg::MODE_CTRL;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Run request per mode
    always_comb
    begin
        place     = 1'b0;
        place_len = '0;
        case (mode_reg)
            sgird_pkg::MODE_REPEAT:
            begin
                place     = 1'b1;
                place_len = count_reg;
            end
            sgird_pkg::MODE_LITERAL:
            begin
                place     = 1'b1;
                place_len = sgird_pkg::COUNT_W'(1);
            end
            default:
            begin
                place = 1'b0;
            end
        endcase
    end

    assign run_end = {1'b0, column_reg} + (sgird_pkg::COL_W + 1)'(place_len);
    assign fits    = run_end <= (sgird_pkg::COL_W + 1)'(line_width);
    assign run     = place && fits;

    // Drop an overflowing run and flag it
    always_comb
    begin
        column_next = column_reg;
        error_next  = error_reg;
        if (run)
        begin
            column_next = run_end[sgird_pkg::COL_W-1:0];
        end
        else if (place)
        begin
            error_next = 1'b1;
        end
    end

    assign line_bad = error_next
                   || (column_next != sgird_pkg::COL_W'(line_width))
                   || (mode_next inside {sgird_pkg::MODE_REPEAT, sgird_pkg::MODE_LITERAL});

    always_comb
    begin
        result.run_valid    = run;
        result.pixel_value  = run ? data_byte : '0;
        result.start_column = run ? column_reg[sgird_pkg::WIDTH_W-1:0] : '0;
        result.run_length   = run ? place_len : '0;
        result.line_done    = line_end;
        result.line_error   = line_end && line_bad;
    end

    assign has_result = run || line_end;

    // Advance on each decoded byte; line end returns everything to the line start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= sgird_pkg::MODE_CTRL;
            count_reg  <= '0;
            column_reg <= '0;
            error_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (line_end)
            begin
                mode_reg   <= sgird_pkg::MODE_CTRL;
                count_reg  <= '0;
                column_reg <= '0;
                error_reg  <= 1'b0;
            end
            else
            begin
                mode_reg   <= mode_next;
                count_reg  <= count_next;
                column_reg <= column_next;
                error_reg  <= error_next;
            end
        end
    end

endmodule

### hdl/sgird_checker.sv
// ----------------------------------------------------------------------------
// sgird_checker
// Port-level checks on the decoder's run channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sgird_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            run_valid,
    input  logic [sgird_pkg::BYTE_W-1:0]    pixel_value,
    input  logic [sgird_pkg::WIDTH_W-1:0]   start_column,
    input  logic [sgird_pkg::COUNT_W-1:0]   run_length,
    input  logic                            line_done,
    input  logic                            line_error
);

    `ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && !out_ready, out_valid && $stable(run_length) && $stable(start_column), "stalled result changed")
    `ASSERT_CLK(a_result_has_content, clk, rst_n, out_valid |-> (run_valid || line_done), "empty result transferred")
    `ASSERT_CLK(a_error_needs_done, clk, rst_n, (out_valid && line_error) |-> line_done, "line_error without line_done")
    `ASSERT_CLK(a_run_nonzero, clk, rst_n, (out_valid && run_valid) |-> (run_length != '0), "run of zero length")
    `ASSERT_CLK(a_no_run_zero, clk, rst_n, (out_valid && !run_valid) |-> (run_length == '0 && start_column == '0 && pixel_value == '0), "run fields set without a run")

endmodule

bind sgi_rle_scanline_decoder_core sgird_checker u_sgird_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (run_out.valid),
    .out_ready    (run_out.ready),
    .run_valid    (run_out.run_valid),
    .pixel_value  (run_out.pixel_value),
    .start_column (run_out.start_column),
    .run_length   (run_out.run_length),
    .line_done    (run_out.line_done),
    .line_error   (run_out.line_error)
);
